### design/sia_pkg.sv
// ----------------------------------------------------------------------------
// sia_pkg
// Shared widths, types and character codes for the signed integer to
// decimal text converter.
// ----------------------------------------------------------------------------
package sia_pkg;

	localparam int VALUE_WIDTH = 32;

	// decimal digits needed for the largest magnitude, 2^(VALUE_WIDTH-1)
	localparam int NDIG = (VALUE_WIDTH * 3) / 10 + 1;
	localparam int IDX_W = $clog2(NDIG);
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	localparam logic [7:0] CHAR_ZERO = 8'd48;
	localparam logic [7:0] CHAR_MINUS = 8'd45;

	typedef logic [NDIG-1:0][3:0] bcd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} dab_stat_t;

endpackage

### design/sia_if.sv
// ----------------------------------------------------------------------------
// sia_if
// Valid/ready channels: signed integer in, one text character out.
// ----------------------------------------------------------------------------
interface sia_value_if import sia_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [VALUE_WIDTH-1:0] value;

	modport source(output valid, output value, input ready);
	modport sink(input valid, input value, output ready);
endinterface

interface sia_char_if;
	logic valid;
	logic ready;
	logic [7:0] character;
	logic last;

	modport source(output valid, output character, output last, input ready);
	modport sink(input valid, input character, input last, output ready);
endinterface

### design/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed integer to its decimal ASCII text, most significant
// character first, with last set on the final character.
// ----------------------------------------------------------------------------
//  channel  dir  fields             handshake
//  num      in   value (signed 32)  valid/ready
//  text     out  character, last    valid/ready
//
// each item is converted in the shift-and-add-3 unit, then emitted at one
// character per cycle (1 to 11 characters) while text is ready
// num.ready is high only while the sequencer is idle
// the last character sits in the output register while the next item is taken
// text stalls hold the output register and pause character generation
// arst_n clears the sequencer and output valid; nothing else needs reset
module signed_int_to_decimal_ascii import sia_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	sia_value_if.sink         num,
	sia_char_if.source        text
);

	typedef enum logic [1:0] {S_IDLE, S_CONV, S_EMIT} state_t;

	state_t             state_q;
	logic               neg_q;
	logic               minus_q;
	logic [IDX_W-1:0]   idx_q;
	logic               out_valid_q;
	logic [7:0]         char_q;
	logic               last_q;

	logic                   accept;
	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;
	bcd_t                   digits;
	dab_stat_t              dab_stat;
	logic [IDX_W-1:0]       top_idx;
	logic                   load;

	assign accept    = num.valid && num.ready;
	assign num.ready = (state_q == S_IDLE);
	assign raw       = VALUE_WIDTH'(num.value);
	// magnitude as unsigned, so the most negative value stays exact
	assign mag       = raw[VALUE_WIDTH-1] ? (~raw) + VALUE_WIDTH'(1) : raw;

	sia_dabble u_dabble (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag    (mag),
		.digits (digits),
		.stat   (dab_stat)
	);

	// highest non-zero digit, zero gives the units digit
	always_comb begin
		top_idx = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (digits[i] != 4'd0) top_idx = IDX_W'(i);
		end
	end

	assign load = !out_valid_q || text.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			neg_q       <= 1'b0;
			minus_q     <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			if (state_q == S_EMIT && load) begin
				out_valid_q <= 1'b1;
			end else if (text.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						neg_q   <= raw[VALUE_WIDTH-1];
						state_q <= S_CONV;
					end
				end
				S_CONV: begin
					if (dab_stat.done) begin
						minus_q <= neg_q;
						idx_q   <= top_idx;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load) begin
						if (minus_q) begin
							char_q  <= CHAR_MINUS;
							last_q  <= 1'b0;
							minus_q <= 1'b0;
						end else begin
							char_q <= CHAR_ZERO + {4'b0000, digits[idx_q]};
							last_q <= (idx_q == '0);
							if (idx_q == '0) begin
								state_q <= S_IDLE;
							end else begin
								idx_q <= idx_q - IDX_W'(1);
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign text.valid     = out_valid_q;
	assign text.character = char_q;
	assign text.last      = last_q;

endmodule

### design/sia_dabble.sv
// ----------------------------------------------------------------------------
// sia_dabble
// Binary to BCD unit: one shift-and-add-3 step per cycle over the
// magnitude, VALUE_WIDTH steps per conversion.
// ----------------------------------------------------------------------------
module sia_dabble import sia_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] mag,
	output bcd_t                   digits,
	output dab_stat_t              stat
);

	logic [VALUE_WIDTH-1:0] bin_q;
	bcd_t                   bcd_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	bcd_t                   adj;
	bcd_t                   bcd_next;

	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		bcd_next[0] = {adj[0][2:0], bin_q[VALUE_WIDTH-1]};
		for (int i = 1; i < NDIG; i++) begin
			bcd_next[i] = {adj[i][2:0], adj[i-1][3]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q  <= CNT_W'(VALUE_WIDTH);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= mag;
			bcd_q <= '0;
		end else if (busy_q) begin
			bin_q <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= bcd_next;
		end
	end

	assign digits    = bcd_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

### design/sia_checker.sv
// ----------------------------------------------------------------------------
// sia_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module sia_checker import sia_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       out_last
);

	// an accepted item keeps the input closed for the conversion
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready straight after an accepted item");

	// input stays closed until the final character of the run is in the output register
	a_closed_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("input ready while a run is still in progress");

	a_char_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_char == CHAR_MINUS) ||
			(out_char >= CHAR_ZERO && out_char <= CHAR_ZERO + 8'd9))
		else $error("character is neither a sign nor a digit");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_char == CHAR_MINUS) |-> !out_last)
		else $error("sign character flagged as last");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
		else $error("output item changed while stalled");

endmodule

bind signed_int_to_decimal_ascii sia_checker u_sia_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (num.valid),
	.in_ready  (num.ready),
	.out_valid (text.valid),
	.out_ready (text.ready),
	.out_char  (text.character),
	.out_last  (text.last)
);
